>>> rtl/core/bcfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcfa_pkg
// Shared types, codes and saturation helpers of the biquad cascade ANC block.
// ----------------------------------------------------------------------------
package bcfa_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_COEF   = 2'd1,
        OP_TAP    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            op;
        logic signed [23:0] ref_sample;
        logic signed [23:0] err_sample;
        logic [7:0]         coef_index;
        logic signed [31:0] coef_value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BQ,
        ST_GAIN,
        ST_FIR,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        TAG_B0,
        TAG_B1,
        TAG_B2,
        TAG_A1,
        TAG_A2,
        TAG_GAIN,
        TAG_FIR
    } t_tag;

    localparam logic [0:0]         CFG_TOTAL_GAIN  = 1'b0;
    localparam logic [0:0]         CFG_FIR_LENGTH  = 1'b1;
    localparam logic signed [31:0] GAIN_RESET      = 32'sd16777216;
    localparam logic [8:0]         LEN_RESET       = 9'd256;
    localparam int                 COEFS_PER_STAGE = 5;
    localparam logic signed [63:0] ACC_LIM         = 64'sh4000_0000_0000_0000;

    function automatic logic ovf24(input logic signed [63:0] v);
        return (v > 64'sd8388607) || (v < -64'sd8388608);
    endfunction

    function automatic logic [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'h7F_FFFF;
        end else if (v < -64'sd8388608) begin
            return 24'h80_0000;
        end
        return v[23:0];
    endfunction

    function automatic logic [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sd140737488355327) begin
            return 48'h7FFF_FFFF_FFFF;
        end else if (v < -64'sd140737488355328) begin
            return 48'h8000_0000_0000;
        end
        return v[47:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/biquad_cascade_fir_anc_residual.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_cascade_fir_anc_residual
// ANC residual: biquad cascade, gain, secondary-path FIR, error subtraction.
// ----------------------------------------------------------------------------
// A sample transaction (opcode 0) runs the FIR over fir_length taps, capped at
// FIR_TAPS. Every multiply goes through one shared 32x24 multiplier; the FIR
// issues one tap per cycle. A clear sweeps the FIR history memory; after reset
// the same sweep runs with the input held off, and configuration writes are
// taken throughout. A two-entry command queue and an output register decouple
// both streams from the core.
// ----------------------------------------------------------------------------
module biquad_cascade_fir_anc_residual
    import bcfa_pkg::*;
#(
    parameter int NUM_STAGES = 10,
    parameter int FIR_TAPS   = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // ref_sample[23:0], err_sample[47:24], coef_index[55:48], coef_value[87:56]
    input  wire logic [87:0] i_s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // residual_error[23:0], cancel_signal[47:24]
    output logic [47:0]      o_m_axis_tdata,
    // saturated[0]
    output logic [0:0]       o_m_axis_tuser
);

    logic signed [31:0] r_total_gain;
    logic [8:0]         r_fir_length;
    logic               cmd_valid;
    t_cmd               cmd;
    logic               cmd_pop;
    logic               booting;
    logic               m_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_gain <= GAIN_RESET;
            r_fir_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_TOTAL_GAIN) begin
                r_total_gain <= i_cfg_data;
            end
            if (i_cfg_addr == CFG_FIR_LENGTH) begin
                r_fir_length <= i_cfg_data[8:0];
            end
        end
    end

    bcfa_front #(
        .NUM_STAGES (NUM_STAGES),
        .FIR_TAPS   (FIR_TAPS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_hold          (booting),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    bcfa_back #(
        .NUM_STAGES (NUM_STAGES),
        .FIR_TAPS   (FIR_TAPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .i_total_gain (r_total_gain),
        .i_fir_length (r_fir_length),
        .o_booting    (booting),
        .o_m_valid    (o_m_axis_tvalid),
        .i_m_ready    (i_m_axis_tready),
        .o_m_data     (o_m_axis_tdata),
        .o_m_sat      (m_sat)
    );

    assign o_m_axis_tuser = m_sat;

endmodule
`default_nettype wire

>>> rtl/core/bcfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcfa_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bcfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/bcfa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcfa_front
// Accept input transactions, drop out-of-range writes, queue commands.
// ----------------------------------------------------------------------------
module bcfa_front
    import bcfa_pkg::*;
#(
    parameter int NUM_STAGES = 10,
    parameter int FIR_TAPS   = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [87:0] i_s_axis_tdata,
    input  wire logic [1:0]  i_s_axis_tuser,
    input  wire logic        i_hold,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_pop
);

    localparam int NCOEF = NUM_STAGES * COEFS_PER_STAGE;

    t_cmd       in_cmd;
    logic       keep;
    logic       push;
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;

    always_comb begin
        in_cmd.op         = t_opcode'(i_s_axis_tuser);
        in_cmd.ref_sample = i_s_axis_tdata[23:0];
        in_cmd.err_sample = i_s_axis_tdata[47:24];
        in_cmd.coef_index = i_s_axis_tdata[55:48];
        in_cmd.coef_value = i_s_axis_tdata[87:56];
        case (in_cmd.op)
            OP_COEF: keep = (32'(in_cmd.coef_index) < NCOEF);
            OP_TAP:  keep = (32'(in_cmd.coef_index) < FIR_TAPS);
            default: keep = 1'b1;
        endcase
    end

    assign o_s_axis_tready = (r_fill != 2'd2) && !i_hold;
    assign push            = i_s_axis_tvalid && o_s_axis_tready && keep;
    assign o_cmd_valid     = (r_fill != 2'd0);
    assign o_cmd           = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(push) - 2'(i_cmd_pop);
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/bcfa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcfa_back
// Sequencer with one shared multiplier: biquad cascade, gain, FIR, residual.
// ----------------------------------------------------------------------------
module bcfa_back
    import bcfa_pkg::*;
#(
    parameter int NUM_STAGES = 10,
    parameter int FIR_TAPS   = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire t_cmd               i_cmd,
    output logic                    o_cmd_pop,
    input  wire logic signed [31:0] i_total_gain,
    input  wire logic [8:0]         i_fir_length,
    output logic                    o_booting,
    output logic                    o_m_valid,
    input  wire logic               i_m_ready,
    output logic [47:0]             o_m_data,
    output logic                    o_m_sat
);

    localparam int NCOEF = NUM_STAGES * COEFS_PER_STAGE;
    localparam int CW    = $clog2(NCOEF);
    localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int TW    = (FIR_TAPS > 1) ? $clog2(FIR_TAPS) : 1;
    localparam int LW0   = $clog2(FIR_TAPS + 1);
    localparam int LENW  = (LW0 > 9) ? LW0 : 9;

    t_state r_state, n_state;

    logic [2:0]         r_step;
    logic [SW-1:0]      r_stage;
    logic [CW-1:0]      r_base;
    logic signed [23:0] r_x, r_y, r_err, r_anti;
    logic               r_asat;
    logic signed [49:0] r_acc1, r_acc2;
    logic signed [47:0] r_d1 [NUM_STAGES];
    logic signed [47:0] r_d2 [NUM_STAGES];
    logic               r_v1, r_v2;
    t_tag               r_tag1, r_tag2;
    logic signed [55:0] r_prod;
    logic signed [63:0] r_acc;
    logic [LENW-1:0]    r_cnt, r_len, len;
    logic [TW-1:0]      r_hidx, r_ptr, r_clr;
    logic               r_boot;
    logic               r_m_valid;
    logic [47:0]        r_m_data;
    logic               r_m_sat;

    logic               iss_v;
    t_tag               iss_tag;
    logic               coef_we, tap_we, hist_we;
    logic [CW-1:0]      coef_raddr;
    logic [TW-1:0]      hist_waddr;
    logic [23:0]        hist_wdata;
    logic [31:0]        coef_dout, tap_dout;
    logic [23:0]        hist_dout;
    logic signed [31:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [55:0] mul_p;
    logic signed [49:0] term;
    logic signed [49:0] wide;
    logic signed [63:0] yr, gr, fsum, ar, rr;
    logic               last_stage;
    logic               out_free;

    // ---- memories
    bcfa_ram #(.WIDTH(32), .DEPTH(NCOEF)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (CW'(i_cmd.coef_index)),
        .i_wdata (i_cmd.coef_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_dout)
    );

    bcfa_ram #(.WIDTH(32), .DEPTH(FIR_TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (TW'(i_cmd.coef_index)),
        .i_wdata (i_cmd.coef_value),
        .i_raddr (r_cnt[TW-1:0]),
        .o_rdata (tap_dout)
    );

    bcfa_ram #(.WIDTH(24), .DEPTH(FIR_TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (r_hidx),
        .o_rdata (hist_dout)
    );

    // ---- shared multiplier operands
    always_comb begin
        case (r_tag1)
            TAG_A1, TAG_A2: begin
                mul_a = coef_dout;
                mul_b = r_y;
            end
            TAG_GAIN: begin
                mul_a = i_total_gain;
                mul_b = r_x;
            end
            TAG_FIR: begin
                mul_a = tap_dout;
                mul_b = hist_dout;
            end
            default: begin
                mul_a = coef_dout;
                mul_b = r_x;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // ---- arithmetic on the landed product
    always_comb begin
        term  = 50'(r_prod >>> 9);
        wide  = term + 50'(r_d1[r_stage]);
        yr    = (64'(wide) + 64'sd524288) >>> 20;
        gr    = (64'(r_prod) + 64'sd8388608) >>> 24;
        fsum  = r_acc + 64'(r_prod);
        ar    = (r_acc + 64'sd268435456) >>> 29;
        rr    = 64'(r_err) - 64'(r_anti);
        len   = (LENW'(i_fir_length) > LENW'(FIR_TAPS)) ? LENW'(FIR_TAPS)
                                                         : LENW'(i_fir_length);
        last_stage = (r_stage == SW'(NUM_STAGES - 1));
        out_free   = !r_m_valid || i_m_ready;
        hist_we    = (r_state == ST_CLEAR) || (r_v2 && (r_tag2 == TAG_GAIN));
        hist_waddr = (r_state == ST_CLEAR) ? r_clr : r_ptr;
        hist_wdata = (r_state == ST_CLEAR) ? 24'd0 : sat24(gr);
        coef_raddr = (r_step < 3'd5) ? (r_base + CW'(r_step)) : r_base;
    end

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        iss_v     = 1'b0;
        iss_tag   = TAG_FIR;
        coef_we   = 1'b0;
        tap_we    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == TW'(FIR_TAPS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_SAMPLE: n_state = ST_BQ;
                        OP_COEF:   coef_we = 1'b1;
                        OP_TAP:    tap_we  = 1'b1;
                        OP_CLEAR:  n_state = ST_CLEAR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_BQ: begin
                iss_v = (r_step < 3'd5);
                case (r_step)
                    3'd0:    iss_tag = TAG_B0;
                    3'd1:    iss_tag = TAG_B1;
                    3'd2:    iss_tag = TAG_B2;
                    3'd3:    iss_tag = TAG_A1;
                    3'd4:    iss_tag = TAG_A2;
                    default: iss_tag = TAG_B0;
                endcase
                if (r_step == 3'd7 && last_stage) begin
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN: begin
                iss_v   = (r_step == 3'd0);
                iss_tag = TAG_GAIN;
                if (r_step == 3'd2) begin
                    n_state = ST_FIR;
                end
            end
            ST_FIR: begin
                if (r_cnt < r_len) begin
                    iss_v = 1'b1;
                end else if (!r_v1 && !r_v2) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // ---- datapath
    always_ff @(posedge i_clk) begin
        r_tag1 <= iss_tag;
        r_tag2 <= r_tag1;
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: begin
                r_step  <= 3'd0;
                r_stage <= '0;
                r_base  <= '0;
                r_x     <= i_cmd.ref_sample;
                r_err   <= i_cmd.err_sample;
            end
            ST_BQ: begin
                if (r_step == 3'd7) begin
                    r_x     <= r_y;
                    r_stage <= r_stage + 1'b1;
                    r_base  <= r_base + CW'(COEFS_PER_STAGE);
                end
            end
            ST_GAIN: begin
                if (r_step == 3'd2) begin
                    r_cnt  <= '0;
                    r_hidx <= r_ptr;
                    r_acc  <= '0;
                    r_len  <= len;
                end
            end
            ST_FIR: begin
                if (r_cnt < r_len) begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_hidx <= (r_hidx == '0) ? TW'(FIR_TAPS - 1) : (r_hidx - 1'b1);
                end
            end
            ST_FIN: begin
                r_anti <= sat24(ar);
                r_asat <= ovf24(ar);
            end
            ST_OUT: begin
                if (out_free) begin
                    r_m_data <= {r_anti, sat24(rr)};
                    r_m_sat  <= r_asat | ovf24(rr);
                end
            end
            default: ;
        endcase
        if (r_state == ST_BQ || r_state == ST_GAIN) begin
            r_step <= r_step + 1'b1;
        end
        if (r_v2) begin
            case (r_tag2)
                TAG_B0: begin
                    r_y    <= sat24(yr);
                    r_acc1 <= 50'(r_d2[r_stage]);
                    r_acc2 <= '0;
                end
                TAG_B1:  r_acc1 <= r_acc1 + term;
                TAG_B2:  r_acc2 <= r_acc2 + term;
                TAG_A1:  r_acc1 <= r_acc1 - term;
                TAG_A2:  r_acc2 <= r_acc2 - term;
                TAG_FIR: begin
                    if (fsum > ACC_LIM) begin
                        r_acc <= ACC_LIM;
                    end else if (fsum < -ACC_LIM) begin
                        r_acc <= -ACC_LIM;
                    end else begin
                        r_acc <= fsum;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_m_valid <= 1'b0;
            r_boot    <= 1'b1;
            r_clr     <= '0;
            r_ptr     <= '0;
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
        end else begin
            r_v1 <= iss_v;
            r_v2 <= r_v1;
            if (r_state == ST_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_ready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr == TW'(FIR_TAPS - 1)) begin
                        r_clr  <= '0;
                        r_ptr  <= '0;
                        r_boot <= 1'b0;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_cmd_valid && i_cmd.op == OP_CLEAR) begin
                        r_clr <= '0;
                        for (int i = 0; i < NUM_STAGES; i++) begin
                            r_d1[i] <= '0;
                            r_d2[i] <= '0;
                        end
                    end
                end
                ST_BQ: begin
                    if (r_step == 3'd7) begin
                        r_d1[r_stage] <= sat48(64'(r_acc1));
                        r_d2[r_stage] <= sat48(64'(r_acc2));
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ptr <= (r_ptr == TW'(FIR_TAPS - 1)) ? '0 : (r_ptr + 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_booting = r_boot;
    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_sat   = r_m_sat;

endmodule
`default_nettype wire
